[rtl/core/uubs_pkg.sv]
// Shared types and constants for the uudecode body stream core.
package uubs_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One queued job: a kind, how many results (1..3), packed bytes
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  nres;
    logic [23:0] word;
  } uubs_entry_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } uubs_qstat_t;

endpackage

[rtl/core/uudecode_body_stream_core.sv]
// Top level of the streaming uudecode body decoder.
//
// Input channel (in_valid/in_ready/in_text_char) takes one body character
// per transfer, starting after the begin line. Result channel (out_valid/
// out_ready) gives out_kind, out_data_byte and out_last_of_run: decoded
// bytes, an end-of-data mark, or a short line error. out_last_of_run flags
// the final result caused by one character.
// Throughput: one character per cycle while the job queue is not full; the
// back end sends one result per cycle while out_ready is high, so a
// four-character group with three bytes keeps pace.
// A result is presented once the job for its character, written to the queue
// at the transfer, has been loaded into the output register.
// A four-entry job queue sits between the character front end and the
// result sender; in_ready drops only while that queue is full, which
// happens when the receiver stalls out_ready for long enough.
// Reset (rst_n low, synchronous) returns to line start and empties the
// queue and the output register. After the end-of-data line, characters
// are accepted and ignored.
module uudecode_body_stream_core import uubs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_data_byte,
  output logic       out_last_of_run
);

  uubs_qstat_t qstat;
  uubs_entry_t push_entry, pop_entry;
  logic        push, pop;

  uubs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_char (in_text_char),
    .qstat        (qstat),
    .push         (push),
    .push_entry   (push_entry)
  );

  uubs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .qstat      (qstat)
  );

  uubs_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .qstat           (qstat),
    .pop_entry       (pop_entry),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

`ifndef NO_ASSERTIONS
  // Non-byte results carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> (out_data_byte == 8'd0))
    else $error("non-byte result with nonzero data");

  // End and error marks are always single results
  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_BYTE) |-> out_last_of_run)
    else $error("mark result not flagged last");

  // Nothing follows the end-of-data mark
  a_end_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_kind == KIND_END) |=> !out_valid)
    else $error("result after end of data");
`endif

endmodule

[rtl/core/uubs_front.sv]
// Front part: accepts characters, tracks line state and builds result jobs.
module uubs_front import uubs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_char,
  input  uubs_qstat_t qstat,
  output logic        push,
  output uubs_entry_t push_entry
);

  localparam logic [1:0] PH_LINE_START = 2'd0;
  localparam logic [1:0] PH_DATA       = 2'd1;
  localparam logic [1:0] PH_SKIP       = 2'd2;
  localparam logic [1:0] PH_DONE       = 2'd3;
  localparam logic [7:0] NL_CHAR       = 8'd10;
  localparam logic [7:0] SPACE_CHAR    = 8'd32;

  logic [1:0]  phase_r, phase_nxt;
  logic [5:0]  remaining_r, remaining_nxt;
  logic [1:0]  group_pos_r, group_pos_nxt;
  logic [17:0] group_bits_r, group_bits_nxt;

  logic [7:0]  diff;
  logic [5:0]  six;
  logic [5:0]  take;
  logic        gen;
  uubs_entry_t entry;
  logic        fire;

  assign diff     = in_text_char - SPACE_CHAR;
  assign six      = diff[5:0];
  assign take     = (remaining_r < 6'd3) ? remaining_r : 6'd3;
  assign in_ready = !qstat.full;
  assign fire     = in_valid && in_ready;

  // Per-character decode step
  always_comb begin
    phase_nxt      = phase_r;
    remaining_nxt  = remaining_r;
    group_pos_nxt  = group_pos_r;
    group_bits_nxt = group_bits_r;
    gen            = 1'b0;
    entry          = '0;
    case (phase_r)
      PH_LINE_START: begin
        if (in_text_char == NL_CHAR) begin
          gen        = 1'b1;
          entry.kind = KIND_SHORT;
          entry.nres = 2'd1;
        end else if (six == 6'd0) begin
          gen        = 1'b1;
          entry.kind = KIND_END;
          entry.nres = 2'd1;
          phase_nxt  = PH_DONE;
        end else begin
          remaining_nxt  = six;
          group_pos_nxt  = 2'd0;
          group_bits_nxt = '0;
          phase_nxt      = PH_DATA;
        end
      end
      PH_DATA: begin
        if (in_text_char == NL_CHAR) begin
          gen            = 1'b1;
          entry.kind     = KIND_SHORT;
          entry.nres     = 2'd1;
          group_pos_nxt  = 2'd0;
          group_bits_nxt = '0;
          remaining_nxt  = 6'd0;
          phase_nxt      = PH_LINE_START;
        end else if (group_pos_r != 2'd3) begin
          group_bits_nxt = {group_bits_r[11:0], six};
          group_pos_nxt  = group_pos_r + 2'd1;
        end else begin
          // fourth character completes the group
          gen            = (take != 6'd0);
          entry.kind     = KIND_BYTE;
          entry.nres     = take[1:0];
          entry.word     = {group_bits_r, six};
          remaining_nxt  = remaining_r - take;
          group_pos_nxt  = 2'd0;
          group_bits_nxt = '0;
          if (remaining_r == take) phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (in_text_char == NL_CHAR) phase_nxt = PH_LINE_START;
      end
      default: begin
      end
    endcase
  end

  assign push       = fire && gen;
  assign push_entry = entry;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LINE_START;
      remaining_r  <= '0;
      group_pos_r  <= '0;
      group_bits_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      remaining_r  <= remaining_nxt;
      group_pos_r  <= group_pos_nxt;
      group_bits_r <= group_bits_nxt;
    end
  end

endmodule

[rtl/core/uubs_fifo.sv]
// Short job queue between the front and back parts.
module uubs_fifo import uubs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  uubs_entry_t push_entry,
  input  logic        pop,
  output uubs_entry_t pop_entry,
  output uubs_qstat_t qstat
);

  uubs_entry_t        mem_r [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QAW:0]       count_r, count_nxt;
  logic               do_push, do_pop;

  assign qstat.full  = (count_r == (QAW+1)'(QDEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_entry   = mem_r[rd_ptr_r];

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (QAW+1)'(1);
    else if (do_pop && !do_push) count_nxt = count_r - (QAW+1)'(1);
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule

[rtl/core/uubs_back.sv]
// Back part: sends queued jobs' results one per cycle while out_ready is high.
module uubs_back import uubs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  uubs_qstat_t qstat,
  input  uubs_entry_t pop_entry,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic        out_last_of_run
);

  uubs_entry_t cur_r;
  logic        cur_valid_r;
  logic [1:0]  idx_r;
  logic        out_fire;
  logic        last;

  assign last            = (idx_r == cur_r.nres - 2'd1);
  assign out_fire        = out_valid && out_ready;
  assign pop             = (!cur_valid_r || (out_fire && last)) && !qstat.empty;
  assign out_valid       = cur_valid_r;
  assign out_kind        = cur_r.kind;
  assign out_last_of_run = last;

  // Byte select, most significant first
  always_comb begin
    case (idx_r)
      2'd0:    out_data_byte = cur_r.word[23:16];
      2'd1:    out_data_byte = cur_r.word[15:8];
      default: out_data_byte = cur_r.word[7:0];
    endcase
  end

  // Control: job valid and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= '0;
    end else if (out_fire) begin
      if (last) cur_valid_r <= 1'b0;
      else      idx_r       <= idx_r + 2'd1;
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_entry;
  end

endmodule
